// ===== hw/rtl/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants of the triangle unit normal block
// Coordinate widths, internal word sizes and the beat structs used between
// the front pipeline, the queue and the back pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_BITS     = 16;
  localparam int NORM_FRAC_BITS = 14;

  localparam int EDGE_W = COORD_BITS + 1;       // edge vector component
  localparam int PROD_W = 2 * EDGE_W;           // signed partial cross term
  localparam int MAG_W  = 2 * COORD_BITS + 1;   // |n_i|
  localparam int LO_W   = (MAG_W + 1) / 2;      // low half of |n_i|
  localparam int HI_W   = MAG_W - LO_W;         // high half of |n_i|
  localparam int SQ_W   = 2 * MAG_W;            // n_i^2
  localparam int SUM_W  = SQ_W + 2;             // sum of three squares
  localparam int ROOT_W = SUM_W / 2;            // floor(sqrt(S))
  localparam int REM_W  = ROOT_W + 1;           // root and divider remainder
  localparam int QUO_W  = NORM_FRAC_BITS + 1;   // quotient magnitude
  localparam int OUT_W  = NORM_FRAC_BITS + 2;   // signed output component

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
  } tun_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic                    degenerate;
  } tun_out_t;

  // classified normal: sign and magnitude per axis, square sum, degenerate flag
  typedef struct packed {
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    logic [SUM_W-1:0]      sum;
  } tun_vec_t;

endpackage

// ===== hw/rtl/tun_front.sv =====
// ----------------------------------------------------------------------------
// tun_front: accept and classify stage
// Six-stage pipeline: edge vectors, cross terms, normal sign and magnitude,
// square partial products, per-axis squares, square sum.
// ----------------------------------------------------------------------------
module tun_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  tun_pkg::tun_in_t item_i,
  input  logic             full_i,
  output logic             stall_o,
  output logic             push_o,
  output tun_pkg::tun_vec_t vec_o
);
  import tun_pkg::*;

  logic       adv;
  logic [5:0] v_q;

  logic signed [EDGE_W-1:0] e_q [3];
  logic signed [EDGE_W-1:0] f_q [3];
  logic signed [PROD_W-1:0] pa_q [3];
  logic signed [PROD_W-1:0] pb_q [3];
  logic signed [PROD_W-1:0] n_d [3];
  logic        [PROD_W-1:0] nabs_d [3];
  tun_vec_t                 s3_q, s4_q, s5_q, s6_q;
  logic [2*LO_W-1:0]        ll_q [3];
  logic [LO_W+HI_W-1:0]     lh_q [3];
  logic [2*HI_W-1:0]        hh_q [3];
  logic [SQ_W-1:0]          sq_q [3];

  // hold the whole pipe while the last beat cannot enter the queue
  assign stall_o = full_i && v_q[5];
  assign adv     = !stall_o;
  assign push_o  = v_q[5] && adv;
  assign vec_o   = s6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[4:0], in_valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i]    = pa_q[i] - pb_q[i];
      nabs_d[i] = n_d[i][PROD_W-1] ? PROD_W'(-n_d[i]) : PROD_W'(n_d[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q[0] <= EDGE_W'(item_i.ax) - EDGE_W'(item_i.bx);
      e_q[1] <= EDGE_W'(item_i.ay) - EDGE_W'(item_i.by);
      e_q[2] <= EDGE_W'(item_i.az) - EDGE_W'(item_i.bz);
      f_q[0] <= EDGE_W'(item_i.bx) - EDGE_W'(item_i.cx);
      f_q[1] <= EDGE_W'(item_i.by) - EDGE_W'(item_i.cy);
      f_q[2] <= EDGE_W'(item_i.bz) - EDGE_W'(item_i.cz);

      pa_q[0] <= e_q[1] * f_q[2];
      pb_q[0] <= f_q[1] * e_q[2];
      pa_q[1] <= e_q[2] * f_q[0];
      pb_q[1] <= f_q[2] * e_q[0];
      pa_q[2] <= f_q[0] * e_q[1];
      pb_q[2] <= e_q[0] * f_q[1];

      s3_q.sum   <= '0;
      s3_q.degen <= (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
      for (int i = 0; i < 3; i++) begin
        s3_q.neg[i] <= n_d[i][PROD_W-1];
        s3_q.mag[i] <= nabs_d[i][MAG_W-1:0];
      end

      s4_q <= s3_q;
      for (int i = 0; i < 3; i++) begin
        ll_q[i] <= s3_q.mag[i][LO_W-1:0] * s3_q.mag[i][LO_W-1:0];
        lh_q[i] <= s3_q.mag[i][LO_W-1:0] * s3_q.mag[i][MAG_W-1:LO_W];
        hh_q[i] <= s3_q.mag[i][MAG_W-1:LO_W] * s3_q.mag[i][MAG_W-1:LO_W];
      end

      s5_q <= s4_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (SQ_W'(hh_q[i]) << (2 * LO_W)) + (SQ_W'(lh_q[i]) << (LO_W + 1))
                 + SQ_W'(ll_q[i]);
      end

      s6_q.degen <= s5_q.degen;
      s6_q.neg   <= s5_q.neg;
      s6_q.mag   <= s5_q.mag;
      s6_q.sum   <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    end
  end

endmodule

// ===== hw/rtl/tun_fifo.sv =====
// ----------------------------------------------------------------------------
// tun_fifo: two-entry queue between front and back
// Decouples the classify pipeline from the root and divide pipeline.
// ----------------------------------------------------------------------------
module tun_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tun_pkg::tun_vec_t wdata_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output tun_pkg::tun_vec_t rdata_o
);
  import tun_pkg::*;

  tun_vec_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule

// ===== hw/rtl/tun_sqrt.sv =====
// ----------------------------------------------------------------------------
// tun_sqrt: pipelined integer square root
// One root bit per stage, digit by digit from the top bit pair of S.
// ----------------------------------------------------------------------------
module tun_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tun_pkg::tun_vec_t vec_i,
  output logic              valid_o,
  output tun_pkg::tun_vec_t vec_o,
  output logic [tun_pkg::ROOT_W-1:0] root_o
);
  import tun_pkg::*;

  logic [ROOT_W:0]   v;
  tun_vec_t          vec   [ROOT_W+1];
  logic [REM_W-1:0]  rem   [ROOT_W+1];
  logic [ROOT_W-1:0] root  [ROOT_W+1];

  assign v[0]    = valid_i;
  assign vec[0]  = vec_i;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W+1:0] r2, trial, diff;
    logic             take;

    always_comb begin
      r2    = {rem[k], vec[k].sum[SUM_W-1-2*k -: 2]};
      trial = (REM_W+2)'({root[k], 2'b01});
      diff  = r2 - trial;
      take  = (r2 >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v[k+1] <= 1'b0;
      else         v[k+1] <= v[k];
    end

    always_ff @(posedge clk_i) begin
      vec[k+1]  <= vec[k];
      rem[k+1]  <= take ? diff[REM_W-1:0] : r2[REM_W-1:0];
      root[k+1] <= {root[k][ROOT_W-2:0], take};
    end
  end

  assign valid_o = v[ROOT_W];
  assign vec_o   = vec[ROOT_W];
  assign root_o  = root[ROOT_W];

endmodule

// ===== hw/rtl/tun_div.sv =====
// ----------------------------------------------------------------------------
// tun_div: pipelined scaled divide, three lanes
// Forms |n_i| * 2^NORM_FRAC_BITS / L one quotient bit per stage, restores sign.
// ----------------------------------------------------------------------------
module tun_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  tun_pkg::tun_vec_t          vec_i,
  input  logic [tun_pkg::ROOT_W-1:0] root_i,
  output logic                       valid_o,
  output tun_pkg::tun_out_t          res_o
);
  import tun_pkg::*;

  logic [QUO_W:0]    v;
  tun_vec_t          vec  [QUO_W+1];
  logic [ROOT_W-1:0] den  [QUO_W+1];
  logic [REM_W-1:0]  rem  [QUO_W+1][3];
  logic [QUO_W-1:0]  quo  [QUO_W+1][3];
  logic signed [OUT_W-1:0] comp [3];

  assign v[0]   = valid_i;
  assign vec[0] = vec_i;
  assign den[0] = root_i;

  for (genvar l = 0; l < 3; l++) begin : g_init
    // |n_i| <= L, so the quotient above bit NORM_FRAC_BITS is zero
    assign rem[0][l] = REM_W'(vec_i.mag[l] >> 1);
    assign quo[0][l] = '0;
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v[j+1] <= 1'b0;
      else         v[j+1] <= v[j];
    end

    always_ff @(posedge clk_i) begin
      vec[j+1] <= vec[j];
      den[j+1] <= den[j];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [REM_W:0] t, diff;
      logic           take;

      always_comb begin
        t    = {rem[j][l], (j == 0) ? vec[j].mag[l][0] : 1'b0};
        diff = t - (REM_W+1)'(den[j]);
        take = (t >= (REM_W+1)'(den[j]));
      end

      always_ff @(posedge clk_i) begin
        rem[j+1][l] <= take ? diff[REM_W-1:0] : t[REM_W-1:0];
        quo[j+1][l] <= {quo[j][l][QUO_W-2:0], take};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (vec[QUO_W].degen) begin
        comp[l] = '0;
      end else if (vec[QUO_W].neg[l]) begin
        comp[l] = -$signed(OUT_W'(quo[QUO_W][l]));
      end else begin
        comp[l] = $signed(OUT_W'(quo[QUO_W][l]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= v[QUO_W];
  end

  always_ff @(posedge clk_i) begin
    res_o.unit_x     <= comp[0];
    res_o.unit_y     <= comp[1];
    res_o.unit_z     <= comp[2];
    res_o.degenerate <= vec[QUO_W].degen;
  end

endmodule

// ===== hw/rtl/triangle_unit_normal_top.sv =====
// ----------------------------------------------------------------------------
// From start to result strobe: 6 classify stages, the queue, 34 root stages,
// 15 divide stages and 1 output register.
// Throughput: one triangle per clock; busy rises only if the queue is full.
// Reset clears all valid bits and the queue; the result data registers are not reset.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// triangle_unit_normal_top: unit face normal of a triangle in fixed point
// Front classifies the cross product, back takes root and divides.
// ----------------------------------------------------------------------------
module triangle_unit_normal_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tun_pkg::tun_in_t  item_i,
  output logic              result_valid_o,
  output tun_pkg::tun_out_t result_o
);
  import tun_pkg::*;

  logic              push, full, empty, sq_valid;
  tun_vec_t          fr_vec, q_vec, sq_vec;
  logic [ROOT_W-1:0] root;

  tun_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .item_i     (item_i),
    .full_i     (full),
    .stall_o    (busy),
    .push_o     (push),
    .vec_o      (fr_vec)
  );

  tun_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fr_vec),
    .pop_i   (!empty),
    .full_o  (full),
    .empty_o (empty),
    .rdata_o (q_vec)
  );

  tun_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!empty),
    .vec_i   (q_vec),
    .valid_o (sq_valid),
    .vec_o   (sq_vec),
    .root_o  (root)
  );

  tun_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .vec_i   (sq_vec),
    .root_i  (root),
    .valid_o (result_valid_o),
    .res_o   (result_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the triangle unit normal block
// Drives triangles through the start/busy command port from a queue, predicts
// the Q1.14 unit normal of each accepted beat and compares every strobed
// result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import tun_pkg::*;

  localparam int  LATENCY    = 57;
  localparam int  N_RANDOM   = 450;
  localparam longint CYCLE_LIMIT = 200000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  logic     busy_q = 1'b0;
  tun_in_t  item_i = '0;
  logic     result_valid_o;
  tun_out_t result_o;

  tun_in_t  pending_tris[$];
  tun_out_t expected_normals[$];
  int       idle_pct = 0;
  int       err_count = 0;
  int       beats_in = 0;
  int       results_seen = 0;
  int       degen_seen = 0;
  longint   cycle_cnt = 0;

  triangle_unit_normal_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #2 clk_i = ~clk_i;

  // Exact floor square root of a nonnegative value below 2^70.
  function automatic logic [69:0] isqrt70(logic [69:0] s);
    logic [69:0] root;
    logic [69:0] cand;
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (70'd1 << b);
      if (cand * cand <= s) root = cand;
    end
    return root;
  endfunction

  function automatic tun_out_t predict_normal(tun_in_t t);
    tun_out_t        r;
    logic signed [69:0] ex, ey, ez, fx, fy, fz;
    logic signed [69:0] n[3];
    logic [69:0]     s, len, mag, q;
    ex = t.ax - t.bx;  ey = t.ay - t.by;  ez = t.az - t.bz;
    fx = t.bx - t.cx;  fy = t.by - t.cy;  fz = t.bz - t.cz;
    n[0] = ey * fz - fy * ez;
    n[1] = ez * fx - fz * ex;
    n[2] = fx * ey - ex * fy;
    s = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    r = '0;
    if (s == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    len = isqrt70(s);
    for (int i = 0; i < 3; i++) begin
      mag = (n[i] < 0) ? 70'(-n[i]) : 70'(n[i]);
      q = (mag << NORM_FRAC_BITS) / len;
      if (n[i] < 0) q = -q;
      case (i)
        0: r.unit_x = q[OUT_W-1:0];
        1: r.unit_y = q[OUT_W-1:0];
        default: r.unit_z = q[OUT_W-1:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tun_in_t mk_tri(logic [15:0] a0, a1, a2, b0, b1, b2,
                                     logic [15:0] c0, c1, c2);
    tun_in_t t;
    t.ax = a0; t.ay = a1; t.az = a2;
    t.bx = b0; t.by = b1; t.bz = b2;
    t.cx = c0; t.cy = c1; t.cz = c2;
    return t;
  endfunction

  // Driver: offer the head of the queue, drop it once the beat is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy_q) begin
        void'(pending_tris.pop_front());
      end
      if (pending_tris.size() > 0 && ($urandom_range(0, 99) >= idle_pct)) begin
        start  <= 1'b1;
        item_i <= pending_tris[0];
      end else begin
        start  <= 1'b0;
      end
    end
  end

  // Busy as sampled at the last rising edge decides whether start was taken.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    busy_q <= busy;
    if (rst_ni && start && !busy) begin
      expected_normals.push_back(predict_normal(item_i));
      beats_in <= beats_in + 1;
    end
    if (rst_ni && result_valid_o) begin
      results_seen <= results_seen + 1;
      if (expected_normals.size() == 0) begin
        $error("result beat with no prediction waiting");
        err_count = err_count + 1;
      end else begin
        tun_out_t e;
        e = expected_normals.pop_front();
        if (result_o.degenerate) degen_seen <= degen_seen + 1;
        if (result_o.unit_x !== e.unit_x) begin
          $error("unit_x expected %0d actual %0d", e.unit_x, result_o.unit_x);
          err_count = err_count + 1;
        end
        if (result_o.unit_y !== e.unit_y) begin
          $error("unit_y expected %0d actual %0d", e.unit_y, result_o.unit_y);
          err_count = err_count + 1;
        end
        if (result_o.unit_z !== e.unit_z) begin
          $error("unit_z expected %0d actual %0d", e.unit_z, result_o.unit_z);
          err_count = err_count + 1;
        end
        if (result_o.degenerate !== e.degenerate) begin
          $error("degenerate expected %0d actual %0d", e.degenerate,
                 result_o.degenerate);
          err_count = err_count + 1;
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int mode;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, degenerate shapes, axis-aligned and unit triangles.
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(mk_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
    pending_tris.push_back(mk_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
    pending_tris.push_back(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_tris.push_back(mk_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                                  16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    pending_tris.push_back(mk_tri(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000, 16'h7fff));
    pending_tris.push_back(mk_tri(16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff));
    pending_tris.push_back(mk_tri(16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000));
    pending_tris.push_back(mk_tri(16'h8000, 16'h8000, 0, 16'h7fff, 16'h8000, 0,
                                  16'h8000, 16'h7fff, 0));
    pending_tris.push_back(mk_tri(16'hffff, 16'hffff, 16'hffff, 0, 0, 0,
                                  1, 1, 1));
    pending_tris.push_back(mk_tri(1, 2, 3, 4, 5, 6, 7, 8, 10));
    pending_tris.push_back(mk_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff,
                                  16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000));

    // Random: four idling phases, mostly wide values with extremes and tiny
    // coordinates mixed in so degenerate and near-degenerate shapes appear.
    for (int ph = 0; ph < 4; ph++) begin
      wait (pending_tris.size() == 0);
      @(negedge clk_i);
      idle_pct = (ph == 0) ? 0 : (ph == 3) ? 19 : 46;
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        logic [15:0] v[9];
        for (int j = 0; j < 9; j++) begin
          mode = $urandom_range(0, 9);
          v[j] = rand_coord(mode < 1 ? 0 : mode < 2 ? 1 : mode < 4 ? 2 : 3);
        end
        if ($urandom_range(0, 19) == 0) begin
          v[6] = v[3]; v[7] = v[4]; v[8] = v[5];
        end
        pending_tris.push_back(mk_tri(v[0], v[1], v[2], v[3], v[4], v[5],
                                      v[6], v[7], v[8]));
      end
    end

    wait (pending_tris.size() == 0);
    @(negedge clk_i);
    wait (expected_normals.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d triangles, checked %0d normals (%0d degenerate)",
             beats_in, results_seen, degen_seen);
    $display("idle phases 0/46/46/19 percent on the command side");
    if (err_count == 0 && expected_normals.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tun_pkg.sv
hw/rtl/tun_front.sv
hw/rtl/tun_fifo.sv
hw/rtl/tun_sqrt.sv
hw/rtl/tun_div.sv
hw/rtl/triangle_unit_normal_top.sv
tb/sv/tb_top.sv
